### hdl/qphs_pkg.sv
`default_nettype none

package qphs_pkg;

  localparam int DEPTH = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int KEY_W = 31;
  localparam int CNT_W = 11;
  localparam int ST_W = 3;
  localparam int BIT_CNT_W = $clog2(KEY_W);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_LIMIT = 1'd1;

  localparam logic [CNT_W-1:0] TABLE_SIZE_RESET = 11'd1021;
  localparam logic [CNT_W-1:0] LOAD_LIMIT_RESET = 11'd512;

  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_SLOT = 3'd2;
  localparam logic [ST_W-1:0] ST_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_ABSENT = 3'd4;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd5;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  localparam int IN_TDATA_W = 32;
  localparam int OUT_BITS = ST_W + CNT_W + CNT_W + 1;
  localparam int OUT_TDATA_W = 32;
  localparam int PROBES_LSB = ST_W;

endpackage

`default_nettype wire

### hdl/quadratic_probe_hash_set.sv
`default_nettype none

// Hash set of nonzero 31-bit keys with quadratic probing over a table of
// DEPTH slots, of which the first table_size are used. Each word on the slave
// side is a lookup or an insert and yields one result word. After reset the
// block clears the table, one slot a cycle, before it takes a word;
// configuration writes are taken during that pass. An item is accepted, its
// key is reduced bit-serially by the table size, each probe does one table
// read and then one compare, and the result is presented; a zero key goes
// straight to the result. One compare-and-subtract unit performs both the
// bit-serial modulo and the incremental probe address update, and the single
// table read port does one read per probe. A finished result waits in the
// output register while the next word is accepted.
module quadratic_probe_hash_set (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire  [qphs_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire  [qphs_pkg::CNT_W-1:0]        cfg_data,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [qphs_pkg::IN_TDATA_W-1:0]   s_tdata,  // key[30:0], zero pad
  input  wire                               s_tuser,  // func
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [qphs_pkg::OUT_TDATA_W-1:0]  m_tdata   // status, probes, key_count,
                                                      // over_load, zero pad
);
  import qphs_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0]           state;
  logic [CNT_W-1:0]     table_size;
  logic [CNT_W-1:0]     load_limit;
  logic [ADDR_W-1:0]    clr_addr;
  logic [KEY_W-1:0]     key_r;
  logic                 func_r;
  logic [KEY_W-1:0]     key_sh;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]     rem;
  logic [ADDR_W-1:0]    slot;
  logic [CNT_W-1:0]     inc;
  logic [CNT_W-1:0]     probe_i;
  logic [CNT_W-1:0]     count;
  logic [ST_W-1:0]      st_r;
  logic [CNT_W-1:0]     probes_r;

  logic [KEY_W-1:0]     mem [DEPTH];
  logic [KEY_W-1:0]     rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [KEY_W-1:0]     mem_wdata;

  logic [CNT_W-1:0]     m_eff;
  logic [CNT_W:0]       red_in;
  logic [CNT_W:0]       red_diff;
  logic [CNT_W-1:0]     red_out;
  logic                 slot_empty;
  logic                 slot_hit;
  logic                 last_probe;
  logic                 place;
  logic                 over_load;

  always_comb begin
    if (table_size < CNT_W'(2)) begin
      m_eff = CNT_W'(2);
    end else if (table_size > CNT_W'(DEPTH)) begin
      m_eff = CNT_W'(DEPTH);
    end else begin
      m_eff = table_size;
    end
  end

  // Shared reduction unit: a value below twice the modulus, brought below it.
  always_comb begin
    case (state)
      S_MOD:   red_in = {rem, key_sh[KEY_W-1]};
      S_ADDR:  red_in = {1'b0, inc} + (CNT_W+1)'(2);
      S_CHECK: red_in = {1'b0, (CNT_W-ADDR_W)'(0), slot} + {1'b0, inc};
      default: red_in = '0;
    endcase
    red_diff = red_in - {1'b0, m_eff};
    red_out = (red_in >= {1'b0, m_eff}) ? red_diff[CNT_W-1:0] : red_in[CNT_W-1:0];
  end

  assign s_tready = (state == S_IDLE);
  assign slot_empty = (rdata == '0);
  assign slot_hit = (rdata == key_r);
  assign last_probe = (probe_i == m_eff);
  assign place = (state == S_CHECK) && slot_empty && (func_r == FUNC_INSERT);
  assign over_load = ({1'b0, count} + (CNT_W+1)'(1)) > {1'b0, load_limit};

  assign mem_we = (state == S_CLEAR) || place;
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : slot;
  assign mem_wdata = (state == S_CLEAR) ? '0 : key_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
      load_limit <= LOAD_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TABLE_SIZE: table_size <= cfg_data;
        REG_LOAD_LIMIT: load_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_RESULT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            key_r <= s_tdata[KEY_W-1:0];
            func_r <= s_tuser;
            key_sh <= s_tdata[KEY_W-1:0];
            rem <= '0;
            bit_cnt <= BIT_CNT_W'(KEY_W - 1);
            probes_r <= '0;
            if (s_tdata[KEY_W-1:0] == '0) begin
              st_r <= ST_INVALID;
              state <= S_RESULT;
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem <= red_out;
          key_sh <= {key_sh[KEY_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          if (bit_cnt == '0) begin
            slot <= red_out[ADDR_W-1:0];
            inc <= m_eff - CNT_W'(1);
            probe_i <= '0;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          inc <= red_out;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (slot_empty) begin
            if (func_r == FUNC_INSERT) begin
              if (count != '1) begin
                count <= count + CNT_W'(1);
              end
              st_r <= ST_INSERTED;
              probes_r <= probe_i + CNT_W'(1);
            end else begin
              st_r <= ST_ABSENT;
            end
            state <= S_RESULT;
          end else if (slot_hit) begin
            st_r <= (func_r == FUNC_INSERT) ? ST_DUPLICATE : ST_FOUND;
            state <= S_RESULT;
          end else if (last_probe) begin
            if (func_r == FUNC_INSERT) begin
              st_r <= ST_NO_SLOT;
              probes_r <= m_eff + CNT_W'(1);
            end else begin
              st_r <= ST_ABSENT;
            end
            state <= S_RESULT;
          end else begin
            probe_i <= probe_i + CNT_W'(1);
            slot <= red_out[ADDR_W-1:0];
            state <= S_ADDR;
          end
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {(OUT_TDATA_W - OUT_BITS)'(0), over_load, count, probes_r, st_r};
            state <= S_IDLE;
          end else begin
            m_tvalid <= m_tvalid;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while the previous one is in progress");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count >= $past(count)))
    else $error("key count went down");

  a_slot_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> ({1'b0, slot} < m_eff))
    else $error("probe address outside the table");

  a_probes_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[PROBES_LSB +: CNT_W]} <= {1'b0, m_eff} + (CNT_W+1)'(1)))
    else $error("probe count above table size plus one");

endmodule

`default_nettype wire
